[rtl/dq_pkg.sv]
// Package with the constants, codes and control types of the double-ended queue.
package dq_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } dq_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } dq_status_e;

  typedef struct packed {
    logic              push_front;
    logic              pop_front;
    logic              push_rear;
    logic              pop_rear;
    logic [WordW-1:0]  value;
  } dq_ctrl_t;

endpackage

[rtl/dq_if.sv]
// Handshake interfaces for the command and result channels of the queue.
interface dq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface dq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic [1:0]         status;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, output data, output status, output is_empty,
                  output is_full, input ready);
  modport sink (input valid, input data, input status, input is_empty,
                input is_full, output ready);
endinterface

[rtl/double_ended_queue_core.sv]
// Top level of the double-ended queue: a row of shifting cells and a result register.
// A result is registered and appears in the cycle after its command is accepted.
// Throughput: one command per cycle while results are taken; the single result
// register holds off new commands only while an earlier result is stalled.
// Reset: asynchronous and active low; all cells become empty at once, no clearing pass.
module double_ended_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  dq_in_if.sink       in_i,
  dq_out_if.source    out_o
);
  import dq_pkg::*;

  logic [WordW-1:0] cell_data [DEPTH];
  logic             cell_vld  [DEPTH];
  logic [WordW-1:0] rear_tap  [DEPTH];
  logic [WordW-1:0] rear_data;

  dq_ctrl_t   ctrl;
  logic       accept, is_empty_now, is_full_now, is_push;
  logic       empty_after, full_after;
  dq_cmd_e    cmd;
  dq_status_e status_d;
  logic [WordW-1:0] data_d;

  logic             out_vld_q;
  logic [WordW-1:0] data_q;
  dq_status_e       status_q;
  logic             empty_q, full_q;

  assign cmd          = dq_cmd_e'(in_i.cmd);
  assign in_i.ready   = !out_vld_q || out_o.ready;
  assign accept       = in_i.valid && in_i.ready;
  assign is_empty_now = !cell_vld[0];
  assign is_full_now  = cell_vld[DEPTH-1];
  assign is_push      = (cmd == CMD_PUSH_REAR) || (cmd == CMD_PUSH_FRONT);

  always_comb begin
    ctrl            = '0;
    ctrl.value      = in_i.value;
    ctrl.push_rear  = accept && (cmd == CMD_PUSH_REAR) && !is_full_now;
    ctrl.push_front = accept && (cmd == CMD_PUSH_FRONT) && !is_full_now;
    ctrl.pop_front  = accept && (cmd == CMD_POP_FRONT) && !is_empty_now;
    ctrl.pop_rear   = accept && (cmd == CMD_POP_REAR) && !is_empty_now;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] left_data, right_data;
    logic             left_vld, right_vld;
    if (i == 0) begin : g_first
      assign left_data = in_i.value;
      assign left_vld  = 1'b1;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
      assign left_vld  = cell_vld[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_vld  = 1'b0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
      assign right_vld  = cell_vld[i+1];
    end
    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_data_i  (left_data),
      .left_vld_i   (left_vld),
      .right_data_i (right_data),
      .right_vld_i  (right_vld),
      .data_o       (cell_data[i]),
      .vld_o        (cell_vld[i]),
      .rear_data_o  (rear_tap[i])
    );
  end

  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | rear_tap[i];
    end
  end

  always_comb begin
    status_d    = ST_DONE;
    data_d      = '0;
    empty_after = is_empty_now;
    full_after  = is_full_now;
    if (is_push) begin
      if (is_full_now) begin
        status_d = ST_FULL;
      end else begin
        empty_after = 1'b0;
        full_after  = cell_vld[DEPTH-2];
      end
    end else if (is_empty_now) begin
      status_d = ST_EMPTY;
      data_d   = '1;
    end else begin
      data_d      = (cmd == CMD_POP_FRONT) ? cell_data[0] : rear_data;
      empty_after = !cell_vld[1];
      full_after  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      out_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q   <= data_d;
      status_q <= status_d;
      empty_q  <= empty_after;
      full_q   <= full_after;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.data     = data_q;
  assign out_o.status   = status_q;
  assign out_o.is_empty = empty_q;
  assign out_o.is_full  = full_q;

endmodule

[rtl/dq_cell.sv]
// One storage cell of the shifting queue row, exchanging words with its neighbors.
module dq_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dq_pkg::dq_ctrl_t        ctrl_i,
  input  logic [dq_pkg::WordW-1:0] left_data_i,
  input  logic                    left_vld_i,
  input  logic [dq_pkg::WordW-1:0] right_data_i,
  input  logic                    right_vld_i,
  output logic [dq_pkg::WordW-1:0] data_o,
  output logic                    vld_o,
  output logic [dq_pkg::WordW-1:0] rear_data_o
);
  import dq_pkg::*;

  logic [WordW-1:0] data_q, data_d;
  logic             vld_q, vld_d;
  logic             is_rear;

  assign is_rear = vld_q && !right_vld_i;

  always_comb begin
    data_d = data_q;
    vld_d  = vld_q;
    if (ctrl_i.push_front) begin
      data_d = left_data_i;
      vld_d  = left_vld_i;
    end else if (ctrl_i.pop_front) begin
      data_d = right_data_i;
      vld_d  = right_vld_i;
    end else if (ctrl_i.push_rear) begin
      if (!vld_q && left_vld_i) begin
        data_d = ctrl_i.value;
        vld_d  = 1'b1;
      end
    end else if (ctrl_i.pop_rear) begin
      if (is_rear) begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign vld_o       = vld_q;
  assign rear_data_o = is_rear ? data_q : '0;

endmodule

[rtl/dq_checker.sv]
// Port-level assertions for the double-ended queue and their bind to the top level.
module dq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_data_i,
  input logic [1:0]  out_status_i,
  input logic        out_empty_i,
  input logic        out_full_i
);
  import dq_pkg::*;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("Accepted command produced no result.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)
      && $stable(out_status_i))
    else $error("Stalled result changed.");

  a_refused_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_EMPTY |-> out_empty_i && out_data_i == '1)
    else $error("Refused pop shows wrong data or flags.");

  a_refused_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_FULL |-> out_full_i && out_data_i == '0)
    else $error("Refused push shows wrong data or flags.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_empty_i && out_full_i))
    else $error("Queue reported empty and full together.");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_data_i   (out_o.data),
  .out_status_i (out_o.status),
  .out_empty_i  (out_o.is_empty),
  .out_full_i   (out_o.is_full)
);
